// ===== design/wsag_pkg.sv =====
// Package for the weight scatter address generator: register codes, defaults and shared types.
package wsag_pkg;

  // Default core counts per layer kind
  localparam int unsigned CONV_CORES_DEF  = 8;
  localparam int unsigned DENSE_CORES_DEF = 16;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_KIND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NET_BASE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 3'd4;

  // Layer kinds
  localparam logic KIND_DENSE = 1'b0;
  localparam logic KIND_CONV  = 1'b1;

  // Cycles the unit length pipeline needs after a register write
  localparam logic [1:0] SETTLE_CYCLES = 2'd2;

  // Layer settings seen by the scheduler
  typedef struct packed {
    logic        layer_kind;
    logic [15:0] net_base;
    logic [15:0] out_count;
    logic [15:0] unit_length;
  } cfg_t;

  // One tagged result
  typedef struct packed {
    logic [6:0]         core_select;
    logic [15:0]        core_addr;
    logic signed [15:0] value_out;
    logic               is_bias;
    logic               layer_done;
    logic               overrun;
  } tag_t;

endpackage

// ===== design/wsag_cfg.sv =====
// Configuration registers and the unit length pipeline.
module wsag_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wsag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wsag_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output wsag_pkg::cfg_t                     cfg,
  output logic                               start,
  output logic                               busy
);

  logic        layer_kind;
  logic [15:0] net_base;
  logic [15:0] out_count;
  logic [15:0] in_count;
  logic [7:0]  filter_size;
  logic [15:0] fs_sq;
  logic [15:0] unit_length;
  logic [1:0]  settle;

  // Register file, settle counter and two-step unit length product
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_kind  <= wsag_pkg::KIND_DENSE;
      net_base    <= 16'd0;
      out_count   <= 16'd1;
      in_count    <= 16'd1;
      filter_size <= 8'd1;
      fs_sq       <= 16'd1;
      unit_length <= 16'd1;
      settle      <= 2'd0;
    end else begin
      fs_sq <= 16'(filter_size) * 16'(filter_size);
      unit_length <= (layer_kind == wsag_pkg::KIND_CONV) ? 16'(in_count * fs_sq) : in_count;
      if (cfg_we) begin
        unique case (cfg_index)
          wsag_pkg::REG_LAYER_KIND: begin
            layer_kind <= cfg_wdata[0];
            settle     <= wsag_pkg::SETTLE_CYCLES;
          end
          wsag_pkg::REG_NET_BASE: begin
            net_base <= cfg_wdata;
            settle   <= wsag_pkg::SETTLE_CYCLES;
          end
          wsag_pkg::REG_OUT_COUNT: begin
            out_count <= cfg_wdata;
            settle    <= wsag_pkg::SETTLE_CYCLES;
          end
          wsag_pkg::REG_IN_COUNT: begin
            in_count <= cfg_wdata;
            settle   <= wsag_pkg::SETTLE_CYCLES;
          end
          wsag_pkg::REG_FILTER_SIZE: begin
            filter_size <= cfg_wdata[7:0];
            settle      <= wsag_pkg::SETTLE_CYCLES;
          end
          default: begin
          end
        endcase
      end else if (settle != 2'd0) begin
        settle <= settle - 2'd1;
      end
    end
  end

  assign cfg.layer_kind  = layer_kind;
  assign cfg.net_base    = net_base;
  assign cfg.out_count   = out_count;
  assign cfg.unit_length = unit_length;

  // Counters reload the cycle after a write, once net_base is in place
  assign start = (settle == wsag_pkg::SETTLE_CYCLES);
  assign busy  = (settle != 2'd0);

endmodule

// ===== design/wsag_sched.sv =====
// Neuron, core and word counters with the per-word tagging logic.
module wsag_sched #(
  parameter int unsigned CONV_CORES  = wsag_pkg::CONV_CORES_DEF,
  parameter int unsigned DENSE_CORES = wsag_pkg::DENSE_CORES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  wsag_pkg::cfg_t     cfg,
  input  logic               start,
  input  logic               step,
  input  logic signed [15:0] data_word,
  input  logic               restart,
  output wsag_pkg::tag_t     tag
);

  logic [15:0] neuron_index, neuron_index_next;
  logic [5:0]  core_index, core_index_next;
  logic [15:0] unit_base, unit_base_next;
  logic [15:0] word_index, word_index_next;
  logic        complete_flag, complete_flag_next;

  logic [15:0] eff_neuron;
  logic [5:0]  eff_core;
  logic [15:0] eff_base;
  logic [15:0] eff_word;
  logic        eff_complete;
  logic        over;
  logic        bias;
  logic [6:0]  cores;
  logic [6:0]  core_inc;
  logic [15:0] neuron_inc;
  logic        last;

  // Restart takes effect before the word is tagged
  always_comb begin
    eff_neuron   = restart ? 16'd0 : neuron_index;
    eff_core     = restart ? 6'd0 : core_index;
    eff_base     = restart ? cfg.net_base : unit_base;
    eff_word     = restart ? 16'd0 : word_index;
    eff_complete = restart ? 1'b0 : complete_flag;
  end

  // Tagging and next counter values
  always_comb begin
    cores      = (cfg.layer_kind == wsag_pkg::KIND_CONV) ? 7'(CONV_CORES) : 7'(DENSE_CORES);
    over       = eff_complete || (eff_neuron >= cfg.out_count);
    bias       = (eff_word == cfg.unit_length);
    core_inc   = {1'b0, eff_core} + 7'd1;
    neuron_inc = eff_neuron + 16'd1;
    last       = (neuron_inc == cfg.out_count);

    tag.value_out   = data_word;
    tag.core_select = over ? 7'd0 : core_inc;
    tag.core_addr   = over ? 16'd0 : (eff_base + eff_word);
    tag.is_bias     = !over && bias;
    tag.layer_done  = !over && bias && last;
    tag.overrun     = over;

    neuron_index_next  = eff_neuron;
    core_index_next    = eff_core;
    unit_base_next     = eff_base;
    word_index_next    = eff_word;
    complete_flag_next = eff_complete;
    if (!over) begin
      if (!bias) begin
        word_index_next = eff_word + 16'd1;
      end else begin
        word_index_next   = 16'd0;
        neuron_index_next = neuron_inc;
        if (core_inc >= cores) begin
          core_index_next = 6'd0;
          unit_base_next  = eff_base + cfg.unit_length + 16'd1;
        end else begin
          core_index_next = core_inc[5:0];
        end
        complete_flag_next = last;
      end
    end
  end

  // Counter registers
  always_ff @(posedge clk) begin
    if (rst || start) begin
      neuron_index  <= 16'd0;
      core_index    <= 6'd0;
      unit_base     <= cfg.net_base;
      word_index    <= 16'd0;
      complete_flag <= 1'b0;
    end else if (step) begin
      neuron_index  <= neuron_index_next;
      core_index    <= core_index_next;
      unit_base     <= unit_base_next;
      word_index    <= word_index_next;
      complete_flag <= complete_flag_next;
    end
  end

endmodule

// ===== design/weight_scatter_address_gen.sv =====
// Top level of the weight scatter address generator: input and result registers.
//
//   channel | signals                                            | direction
//   --------+----------------------------------------------------+----------
//   in      | in_valid, in_stall, data_word, restart             | sink
//   out     | out_valid, out_stall, core_select, core_addr,      | source
//           | value_out, is_bias, layer_done, overrun            |
//   cfg     | cfg_we, cfg_index, cfg_wdata                       | sink
//
// One word per cycle while in_stall is low; results leave through the result register.
// Counters update in the single step between the input and result registers.
// A write to a defined register holds in_stall while the unit length product settles.
// Reset (rst, synchronous) loads the register defaults and clears both stages.
// out_stall backs up into in_stall in the same cycle once the input register is full.
module weight_scatter_address_gen #(
  parameter int unsigned CONV_CORES  = wsag_pkg::CONV_CORES_DEF,
  parameter int unsigned DENSE_CORES = wsag_pkg::DENSE_CORES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wsag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsag_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              data_word,
  input  logic                            restart,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [6:0]                      core_select,
  output logic [15:0]                     core_addr,
  output logic signed [15:0]              value_out,
  output logic                            is_bias,
  output logic                            layer_done,
  output logic                            overrun
);

  wsag_pkg::cfg_t cfg;
  wsag_pkg::tag_t tag;
  logic           start;
  logic           busy;

  logic               in_full;
  logic signed [15:0] data_r;
  logic               restart_r;
  logic               step;
  logic               take;

  wsag_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .start     (start),
    .busy      (busy)
  );

  wsag_sched #(
    .CONV_CORES  (CONV_CORES),
    .DENSE_CORES (DENSE_CORES)
  ) u_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (start),
    .step      (step),
    .data_word (data_r),
    .restart   (restart_r),
    .tag       (tag)
  );

  // Handshake: a word moves on when the result register is free or draining
  assign step     = in_full && (!out_valid || !out_stall);
  assign in_stall = busy || (in_full && !step);
  assign take     = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r    <= data_word;
      restart_r <= restart;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      core_select <= tag.core_select;
      core_addr   <= tag.core_addr;
      value_out   <= tag.value_out;
      is_bias     <= tag.is_bias;
      layer_done  <= tag.layer_done;
      overrun     <= tag.overrun;
    end
  end

endmodule

// ===== design/wsag_checker.sv =====
// Port-level checker for the weight scatter address generator, bound to the top level.
module wsag_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [wsag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [6:0]                      core_select,
  input logic [15:0]                     core_addr,
  input logic                            is_bias,
  input logic                            layer_done,
  input logic                            overrun
);

  // An overrun word never carries a write target
  a_overrun_no_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && overrun |-> core_select == 7'd0 && core_addr == 16'd0 && !is_bias)
    else $error("overrun transfer carries a write target");

  // Layer completion only on a real bias write
  a_done_on_bias: assert property (@(posedge clk) disable iff (rst)
    out_valid && layer_done |-> is_bias && !overrun && core_select != 7'd0)
    else $error("layer_done without a bias write");

  // A write to a known register holds off input while unit length settles
  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == wsag_pkg::REG_LAYER_KIND || cfg_index == wsag_pkg::REG_NET_BASE ||
               cfg_index == wsag_pkg::REG_OUT_COUNT || cfg_index == wsag_pkg::REG_IN_COUNT ||
               cfg_index == wsag_pkg::REG_FILTER_SIZE) |=> in_stall)
    else $error("input accepted right after a register write");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(core_addr) && $stable(core_select))
    else $error("stalled result changed");

endmodule

bind weight_scatter_address_gen wsag_checker u_wsag_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_we      (cfg_we),
  .cfg_index   (cfg_index),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .core_select (core_select),
  .core_addr   (core_addr),
  .is_bias     (is_bias),
  .layer_done  (layer_done),
  .overrun     (overrun)
);
